### rtl/core/apsp_pkg.sv
// Shared types and constants for the all-pairs shortest path block.
// Depends on nothing; every other file of the block refers to it by scoped names.
package apsp_pkg;

	// Defaults for the top-level parameters.
	localparam int MAX_VERTICES_DEF = 8;
	localparam int WEIGHT_BITS_DEF  = 16;

	// Fixed field widths of the request and result channels.
	localparam int VTX_W    = 3;
	localparam int WEIGHT_W = 16;
	localparam int NV_W     = 4;
	localparam int DIST_W   = 19;

	// Widths that cover the largest supported vertex count.
	localparam int IDX_W  = 4;
	localparam int VCNT_W = 5;

	// Saturation bounds of the reported distance.
	localparam int DIST_MIN = -262144;
	localparam int DIST_MAX = 262143;

	// Register reset value.
	localparam logic [NV_W-1:0] NUM_VERTICES_RST = 4'd8;

	// Result status codes.
	typedef enum logic [1:0] {
		RS_OK        = 2'd0,
		RS_NEG_CYCLE = 2'd1,
		RS_TOO_FEW   = 2'd2
	} res_status_t;

	// Datapath operations, executed one per cycle in order of issue.
	typedef enum logic [3:0] {
		OP_NOP,
		OP_INIT_POT,
		OP_BF,
		OP_NC,
		OP_DJ_INIT,
		OP_SCAN,
		OP_PICK,
		OP_RELAX,
		OP_EMIT,
		OP_STATUS
	} op_t;

	// Controller states.
	typedef enum logic [3:0] {
		S_IDLE,
		S_CHECK,
		S_BF,
		S_NC,
		S_NC_DRAIN,
		S_NC_DEC,
		S_DJ_INIT,
		S_SCAN,
		S_SCAN_DRAIN,
		S_SCAN_DEC,
		S_RELAX,
		S_EMIT,
		S_STATUS
	} state_t;

	// Command from the controller to the datapath.
	typedef struct packed {
		op_t              op;
		logic [IDX_W-1:0] u;
		logic [IDX_W-1:0] w;
		res_status_t      code;
		logic             last;
		logic             clear;
	} dp_cmd_t;

	// Status from the datapath to the controller.
	typedef struct packed {
		logic              any_edge;
		logic              neg;
		logic              best_found;
		logic [IDX_W-1:0]  best;
		logic [VCNT_W-1:0] v;
		logic              out_busy;
	} dp_status_t;

endpackage

### rtl/core/apsp_edge_if.sv
// Edge request channel: valid, ready and one directed weighted edge.
// Depends on apsp_pkg for the field widths.
interface apsp_edge_if;
	logic                               valid;
	logic                               ready;
	logic [apsp_pkg::VTX_W-1:0]         src_vertex;
	logic [apsp_pkg::VTX_W-1:0]         dst_vertex;
	logic signed [apsp_pkg::WEIGHT_W-1:0] weight;
	logic                               last_edge;

	modport source (output valid, src_vertex, dst_vertex, weight, last_edge, input ready);
	modport sink (input valid, src_vertex, dst_vertex, weight, last_edge, output ready);
endinterface

### rtl/core/apsp_result_if.sv
// Result request channel: valid, ready and one vertex-pair distance or status.
// Depends on apsp_pkg for the field widths.
interface apsp_result_if;
	logic                               valid;
	logic                               ready;
	logic [1:0]                         status;
	logic [apsp_pkg::VTX_W-1:0]         from_vertex;
	logic [apsp_pkg::VTX_W-1:0]         to_vertex;
	logic signed [apsp_pkg::DIST_W-1:0] distance;
	logic                               reachable;
	logic                               last;

	modport source (output valid, status, from_vertex, to_vertex, distance, reachable, last,
		input ready);
	modport sink (input valid, status, from_vertex, to_vertex, distance, reachable, last,
		output ready);
endinterface

### rtl/core/apsp_datapath.sv
// Datapath: edge memory, potentials, Dijkstra registers and the result register.
// Depends on apsp_pkg; commanded by apsp_ctrl one operation per cycle.
module apsp_datapath #(
	parameter int MAX_VERTICES = apsp_pkg::MAX_VERTICES_DEF,
	parameter int WEIGHT_BITS  = apsp_pkg::WEIGHT_BITS_DEF
) (
	input  logic                                clk,
	input  logic                                arst_n,
	input  logic                                cfg_wr_en,
	input  logic [apsp_pkg::NV_W-1:0]           cfg_wr_data,
	input  logic                                load_en,
	input  logic [apsp_pkg::VTX_W-1:0]          src_vertex,
	input  logic [apsp_pkg::VTX_W-1:0]          dst_vertex,
	input  logic [apsp_pkg::WEIGHT_W-1:0]       weight,
	input  apsp_pkg::dp_cmd_t                   cmd,
	input  logic                                out_ready,
	output apsp_pkg::dp_status_t                stat,
	output logic                                out_valid,
	output logic [1:0]                          out_status,
	output logic [apsp_pkg::VTX_W-1:0]          out_from,
	output logic [apsp_pkg::VTX_W-1:0]          out_to,
	output logic signed [apsp_pkg::DIST_W-1:0]  out_distance,
	output logic                                out_reachable,
	output logic                                out_last
);
	localparam int M  = MAX_VERTICES;
	localparam int IW = (M > 2) ? $clog2(M) : 1;
	localparam int VW = $clog2(M + 1);
	localparam int NE = M * M;
	localparam int AW = $clog2(NE);
	localparam int DW = WEIGHT_BITS + 16;
	localparam logic signed [DW-1:0] DMIN = DW'(apsp_pkg::DIST_MIN);
	localparam logic signed [DW-1:0] DMAX = DW'(apsp_pkg::DIST_MAX);

	// Configuration register.
	logic [apsp_pkg::NV_W-1:0] nv_q;
	logic [VW-1:0]             v;

	always_ff @(posedge clk or negedge arst_n) begin
		if (!arst_n) begin
			nv_q <= apsp_pkg::NUM_VERTICES_RST;
		end else if (cfg_wr_en) begin
			nv_q <= cfg_wr_data;
		end
	end

	// A vertex count above the supported maximum saturates to it.
	assign v = (int'(nv_q) > M) ? VW'(M) : VW'(nv_q);

	// Edge memory with one write and one registered read port.
	logic [WEIGHT_BITS-1:0] mem [NE];
	logic [NE-1:0]          present_q;
	logic [AW-1:0]          wr_addr;
	logic [AW-1:0]          rd_addr;
	logic                   wr_ok;
	logic [WEIGHT_BITS-1:0] rd_s1;

	assign wr_ok   = (int'(src_vertex) < M) && (int'(dst_vertex) < M);
	assign wr_addr = AW'(int'(src_vertex) * M + int'(dst_vertex));
	assign rd_addr = AW'(int'(cmd.u[IW-1:0]) * M + int'(cmd.w[IW-1:0]));

	always_ff @(posedge clk) begin
		if (load_en && wr_ok) begin
			mem[wr_addr] <= WEIGHT_BITS'(weight);
		end
		rd_s1 <= mem[rd_addr];
	end

	// Presence bits, cleared together at the end of every run.
	always_ff @(posedge clk or negedge arst_n) begin
		if (!arst_n) begin
			present_q <= '0;
		end else if (cmd.clear) begin
			present_q <= '0;
		end else if (load_en && wr_ok) begin
			present_q[wr_addr] <= 1'b1;
		end
	end

	// Any stored edge with both endpoints inside the graph.
	logic any_edge;
	always_comb begin
		any_edge = 1'b0;
		for (int a = 0; a < M; a++) begin
			for (int b = 0; b < M; b++) begin
				if (a < int'(v) && b < int'(v) && present_q[a * M + b]) begin
					any_edge = 1'b1;
				end
			end
		end
	end

	// Operation stage, aligned with the registered memory read.
	apsp_pkg::dp_cmd_t cmd_s1;
	always_ff @(posedge clk or negedge arst_n) begin
		if (!arst_n) begin
			cmd_s1 <= '0;
		end else begin
			cmd_s1 <= cmd;
		end
	end

	logic [IW-1:0] u_s1;
	logic [IW-1:0] w_s1;
	logic [AW-1:0] e_s1;
	assign u_s1 = cmd_s1.u[IW-1:0];
	assign w_s1 = cmd_s1.w[IW-1:0];
	assign e_s1 = AW'(int'(u_s1) * M + int'(w_s1));

	// Working registers of the run.
	logic signed [DW-1:0] pot_q [M];
	logic signed [DW-1:0] td_q [M];
	logic [M-1:0]         tvalid_q;
	logic [M-1:0]         visited_q;
	logic signed [DW-1:0] base_q;
	logic [IW-1:0]        best_q;
	logic                 best_found_q;
	logic                 neg_q;

	// Arithmetic of the current operation.
	logic signed [DW-1:0] wt;
	logic signed [DW-1:0] pu;
	logic signed [DW-1:0] pw;
	logic signed [DW-1:0] bf_sum;
	logic                 bf_hit;
	logic signed [DW-1:0] nd;
	logic                 relax_hit;
	logic                 scan_hit;
	logic signed [DW-1:0] emit_raw;
	logic signed [DW-1:0] emit_sat;

	always_comb begin
		wt        = DW'($signed(rd_s1));
		pu        = pot_q[u_s1];
		pw        = pot_q[w_s1];
		bf_sum    = pu + wt;
		bf_hit    = present_q[e_s1] && (bf_sum < pw);
		nd        = base_q + wt - pw;
		relax_hit = present_q[e_s1] && !visited_q[w_s1] &&
			(!tvalid_q[w_s1] || (nd < td_q[w_s1]));
		scan_hit  = !visited_q[u_s1] && tvalid_q[u_s1] &&
			((u_s1 == '0) || !best_found_q || (td_q[u_s1] < td_q[best_q]));
		emit_raw  = td_q[w_s1] - pu + pw;
		if (emit_raw < DMIN) begin
			emit_sat = DMIN;
		end else if (emit_raw > DMAX) begin
			emit_sat = DMAX;
		end else begin
			emit_sat = emit_raw;
		end
	end

	// Execution of the operation in the stage.
	always_ff @(posedge clk) begin
		unique case (cmd_s1.op)
			apsp_pkg::OP_INIT_POT: begin
				for (int k = 0; k < M; k++) begin
					pot_q[k] <= '0;
				end
				neg_q <= 1'b0;
			end
			apsp_pkg::OP_BF: begin
				if (bf_hit) begin
					pot_q[w_s1] <= bf_sum;
				end
			end
			apsp_pkg::OP_NC: begin
				if (bf_hit) begin
					neg_q <= 1'b1;
				end
			end
			apsp_pkg::OP_DJ_INIT: begin
				for (int k = 0; k < M; k++) begin
					td_q[k] <= '0;
				end
				tvalid_q     <= M'(1) << u_s1;
				visited_q    <= '0;
				best_found_q <= 1'b0;
			end
			apsp_pkg::OP_SCAN: begin
				if (u_s1 == '0) begin
					best_found_q <= scan_hit;
				end else if (scan_hit) begin
					best_found_q <= 1'b1;
				end
				if (scan_hit) begin
					best_q <= u_s1;
				end
			end
			apsp_pkg::OP_PICK: begin
				visited_q[best_q] <= 1'b1;
				base_q            <= td_q[best_q] + pot_q[best_q];
			end
			apsp_pkg::OP_RELAX: begin
				if (relax_hit) begin
					tvalid_q[w_s1] <= 1'b1;
					td_q[w_s1]     <= nd;
				end
			end
			default: begin
			end
		endcase
	end

	// Result register; the controller issues a result only when it is free.
	logic                               out_valid_q;
	logic [1:0]                         status_q;
	logic [apsp_pkg::VTX_W-1:0]         from_q;
	logic [apsp_pkg::VTX_W-1:0]         to_q;
	logic signed [apsp_pkg::DIST_W-1:0] dist_q;
	logic                               reach_q;
	logic                               last_q;
	logic                               emit_op;

	assign emit_op = (cmd_s1.op == apsp_pkg::OP_EMIT) || (cmd_s1.op == apsp_pkg::OP_STATUS);

	always_ff @(posedge clk or negedge arst_n) begin
		if (!arst_n) begin
			out_valid_q <= 1'b0;
		end else if (emit_op) begin
			out_valid_q <= 1'b1;
		end else if (out_ready) begin
			out_valid_q <= 1'b0;
		end
	end

	always_ff @(posedge clk) begin
		if (cmd_s1.op == apsp_pkg::OP_EMIT) begin
			status_q <= apsp_pkg::RS_OK;
			from_q   <= apsp_pkg::VTX_W'(u_s1);
			to_q     <= apsp_pkg::VTX_W'(w_s1);
			reach_q  <= tvalid_q[w_s1];
			dist_q   <= tvalid_q[w_s1] ? apsp_pkg::DIST_W'(emit_sat) : '0;
			last_q   <= cmd_s1.last;
		end else if (cmd_s1.op == apsp_pkg::OP_STATUS) begin
			status_q <= cmd_s1.code;
			from_q   <= '0;
			to_q     <= '0;
			reach_q  <= 1'b0;
			dist_q   <= '0;
			last_q   <= 1'b1;
		end
	end

	assign out_valid     = out_valid_q;
	assign out_status    = status_q;
	assign out_from      = from_q;
	assign out_to        = to_q;
	assign out_distance  = dist_q;
	assign out_reachable = reach_q;
	assign out_last      = last_q;

	// Status towards the controller.
	always_comb begin
		stat            = '0;
		stat.any_edge   = any_edge;
		stat.neg        = neg_q;
		stat.best_found = best_found_q;
		stat.best       = apsp_pkg::IDX_W'(best_q);
		stat.v          = apsp_pkg::VCNT_W'(v);
		stat.out_busy   = out_valid_q || emit_op;
	end

endmodule

### rtl/core/apsp_ctrl.sv
// Controller: sequences loading, Bellman-Ford, the cycle check, Dijkstra and output.
// Depends on apsp_pkg; drives apsp_datapath through command and status structs.
module apsp_ctrl #(
	parameter int MAX_VERTICES = apsp_pkg::MAX_VERTICES_DEF
) (
	input  logic                 clk,
	input  logic                 arst_n,
	input  logic                 start,
	input  apsp_pkg::dp_status_t stat,
	output apsp_pkg::dp_cmd_t    cmd,
	output logic                 edge_ready
);
	localparam int M  = MAX_VERTICES;
	localparam int IW = (M > 2) ? $clog2(M) : 1;
	localparam int VW = $clog2(M + 1);

	apsp_pkg::state_t      state_q, state_d;
	logic [IW-1:0]         u_q, u_d, w_q, w_d, i_q, i_d;
	logic [VW-1:0]         r_q, r_d;
	apsp_pkg::res_status_t code_q, code_d;

	logic [VW-1:0] v;
	logic [IW-1:0] vm1;
	logic          u_last, w_last, i_last, r_last, r_done;

	assign v      = stat.v[VW-1:0];
	assign vm1    = IW'(v - VW'(1));
	assign u_last = (u_q == vm1);
	assign w_last = (w_q == vm1);
	assign i_last = (i_q == vm1);
	assign r_last = (r_q == (v - VW'(1)));
	assign r_done = (r_q == v);

	always_ff @(posedge clk or negedge arst_n) begin
		if (!arst_n) begin
			state_q <= apsp_pkg::S_IDLE;
			u_q     <= '0;
			w_q     <= '0;
			i_q     <= '0;
			r_q     <= '0;
			code_q  <= apsp_pkg::RS_OK;
		end else begin
			state_q <= state_d;
			u_q     <= u_d;
			w_q     <= w_d;
			i_q     <= i_d;
			r_q     <= r_d;
			code_q  <= code_d;
		end
	end

	// Next state.
	always_comb begin
		state_d = state_q;
		unique case (state_q)
			apsp_pkg::S_IDLE: begin
				if (start) state_d = apsp_pkg::S_CHECK;
			end
			apsp_pkg::S_CHECK: begin
				if (v < VW'(2) || !stat.any_edge) state_d = apsp_pkg::S_STATUS;
				else state_d = apsp_pkg::S_BF;
			end
			apsp_pkg::S_BF: begin
				if (r_last && u_last && w_last) state_d = apsp_pkg::S_NC;
			end
			apsp_pkg::S_NC: begin
				if (u_last && w_last) state_d = apsp_pkg::S_NC_DRAIN;
			end
			apsp_pkg::S_NC_DRAIN: begin
				state_d = apsp_pkg::S_NC_DEC;
			end
			apsp_pkg::S_NC_DEC: begin
				if (stat.neg) state_d = apsp_pkg::S_STATUS;
				else state_d = apsp_pkg::S_DJ_INIT;
			end
			apsp_pkg::S_DJ_INIT: begin
				state_d = apsp_pkg::S_SCAN;
			end
			apsp_pkg::S_SCAN: begin
				if (u_last) state_d = apsp_pkg::S_SCAN_DRAIN;
			end
			apsp_pkg::S_SCAN_DRAIN: begin
				state_d = apsp_pkg::S_SCAN_DEC;
			end
			apsp_pkg::S_SCAN_DEC: begin
				if (stat.best_found) state_d = apsp_pkg::S_RELAX;
				else state_d = apsp_pkg::S_EMIT;
			end
			apsp_pkg::S_RELAX: begin
				if (w_last) begin
					if (r_done) state_d = apsp_pkg::S_EMIT;
					else state_d = apsp_pkg::S_SCAN;
				end
			end
			apsp_pkg::S_EMIT: begin
				if (!stat.out_busy && w_last) begin
					if (i_last) state_d = apsp_pkg::S_IDLE;
					else state_d = apsp_pkg::S_DJ_INIT;
				end
			end
			apsp_pkg::S_STATUS: begin
				if (!stat.out_busy) state_d = apsp_pkg::S_IDLE;
			end
			default: state_d = apsp_pkg::S_IDLE;
		endcase
	end

	// Commands and loop counters.
	always_comb begin
		cmd        = '0;
		cmd.op     = apsp_pkg::OP_NOP;
		cmd.code   = code_q;
		edge_ready = 1'b0;
		u_d        = u_q;
		w_d        = w_q;
		i_d        = i_q;
		r_d        = r_q;
		code_d     = code_q;
		unique case (state_q)
			apsp_pkg::S_IDLE: begin
				edge_ready = 1'b1;
			end
			apsp_pkg::S_CHECK: begin
				if (v < VW'(2) || !stat.any_edge) begin
					code_d = apsp_pkg::RS_TOO_FEW;
				end else begin
					cmd.op = apsp_pkg::OP_INIT_POT;
					u_d    = '0;
					w_d    = '0;
					r_d    = '0;
				end
			end
			apsp_pkg::S_BF, apsp_pkg::S_NC: begin
				cmd.op = (state_q == apsp_pkg::S_BF) ? apsp_pkg::OP_BF : apsp_pkg::OP_NC;
				cmd.u  = apsp_pkg::IDX_W'(u_q);
				cmd.w  = apsp_pkg::IDX_W'(w_q);
				w_d    = w_last ? '0 : w_q + IW'(1);
				if (w_last) begin
					u_d = u_last ? '0 : u_q + IW'(1);
					if (u_last) r_d = r_q + VW'(1);
				end
			end
			apsp_pkg::S_NC_DRAIN: begin
			end
			apsp_pkg::S_NC_DEC: begin
				if (stat.neg) code_d = apsp_pkg::RS_NEG_CYCLE;
				i_d = '0;
			end
			apsp_pkg::S_DJ_INIT: begin
				cmd.op = apsp_pkg::OP_DJ_INIT;
				cmd.u  = apsp_pkg::IDX_W'(i_q);
				r_d    = '0;
				u_d    = '0;
			end
			apsp_pkg::S_SCAN: begin
				cmd.op = apsp_pkg::OP_SCAN;
				cmd.u  = apsp_pkg::IDX_W'(u_q);
				u_d    = u_last ? '0 : u_q + IW'(1);
			end
			apsp_pkg::S_SCAN_DRAIN: begin
			end
			apsp_pkg::S_SCAN_DEC: begin
				w_d = '0;
				if (stat.best_found) begin
					cmd.op = apsp_pkg::OP_PICK;
					r_d    = r_q + VW'(1);
				end
			end
			apsp_pkg::S_RELAX: begin
				cmd.op = apsp_pkg::OP_RELAX;
				cmd.u  = stat.best;
				cmd.w  = apsp_pkg::IDX_W'(w_q);
				w_d    = w_last ? '0 : w_q + IW'(1);
				u_d    = '0;
			end
			apsp_pkg::S_EMIT: begin
				if (!stat.out_busy) begin
					cmd.op    = apsp_pkg::OP_EMIT;
					cmd.u     = apsp_pkg::IDX_W'(i_q);
					cmd.w     = apsp_pkg::IDX_W'(w_q);
					cmd.last  = i_last && w_last;
					cmd.clear = i_last && w_last;
					w_d       = w_last ? '0 : w_q + IW'(1);
					if (w_last) i_d = i_q + IW'(1);
				end
			end
			apsp_pkg::S_STATUS: begin
				if (!stat.out_busy) begin
					cmd.op    = apsp_pkg::OP_STATUS;
					cmd.last  = 1'b1;
					cmd.clear = 1'b1;
				end
			end
			default: begin
			end
		endcase
	end

endmodule

### rtl/core/all_pairs_shortest_path_johnson_top.sv
// Top level of the all-pairs shortest path block: channels, controller and datapath.
// Depends on apsp_pkg, apsp_edge_if, apsp_result_if, apsp_ctrl and apsp_datapath.

// Edges are taken one per cycle while the block is idle; an edge repeats its
// endpoints to overwrite an earlier weight. The edge flagged last starts a run,
// during which no edge is taken. With V vertices a run does Bellman-Ford rounds
// over all vertex pairs, a negative-cycle check, then per source up to V rounds of
// a minimum scan, a drain and a decision state and a relaxation sweep, one at a
// time through the single read port of the edge memory and one relaxation unit.
// Results leave from_vertex major through a single output register, which takes
// a new result only after the last one is accepted. A run that finds a negative
// cycle, or has fewer than two vertices or no usable edge, gives one status
// result instead. The edge store is empty again after every run.
module all_pairs_shortest_path_johnson_top #(
	parameter int MAX_VERTICES = apsp_pkg::MAX_VERTICES_DEF,
	parameter int WEIGHT_BITS  = apsp_pkg::WEIGHT_BITS_DEF
) (
	input  logic                      clk,
	input  logic                      arst_n,
	input  logic                      cfg_wr_en,
	input  logic [apsp_pkg::NV_W-1:0] cfg_wr_data,
	apsp_edge_if.sink                 edge_in,
	apsp_result_if.source             result_out
);
	apsp_pkg::dp_cmd_t    cmd;
	apsp_pkg::dp_status_t stat;
	logic                 edge_ready;
	logic                 edge_accept;

	// An edge request is accepted when valid meets ready.
	assign edge_in.ready = edge_ready;
	assign edge_accept   = edge_in.valid && edge_ready;

	apsp_ctrl #(
		.MAX_VERTICES(MAX_VERTICES)
	) u_ctrl (
		.clk       (clk),
		.arst_n    (arst_n),
		.start     (edge_accept && edge_in.last_edge),
		.stat      (stat),
		.cmd       (cmd),
		.edge_ready(edge_ready)
	);

	apsp_datapath #(
		.MAX_VERTICES(MAX_VERTICES),
		.WEIGHT_BITS (WEIGHT_BITS)
	) u_datapath (
		.clk          (clk),
		.arst_n       (arst_n),
		.cfg_wr_en    (cfg_wr_en),
		.cfg_wr_data  (cfg_wr_data),
		.load_en      (edge_accept),
		.src_vertex   (edge_in.src_vertex),
		.dst_vertex   (edge_in.dst_vertex),
		.weight       (edge_in.weight),
		.cmd          (cmd),
		.out_ready    (result_out.ready),
		.stat         (stat),
		.out_valid    (result_out.valid),
		.out_status   (result_out.status),
		.out_from     (result_out.from_vertex),
		.out_to       (result_out.to_vertex),
		.out_distance (result_out.distance),
		.out_reachable(result_out.reachable),
		.out_last     (result_out.last)
	);

	// A status result is always the only and final result of its run.
	a_status_last: assert property (@(posedge clk) disable iff (!arst_n)
		result_out.valid && (result_out.status != apsp_pkg::RS_OK) |-> result_out.last)
		else $error("status result without last");

	// A status result carries no pair and no distance.
	a_status_clean: assert property (@(posedge clk) disable iff (!arst_n)
		result_out.valid && (result_out.status != apsp_pkg::RS_OK) |->
		(result_out.from_vertex == '0) && (result_out.to_vertex == '0) &&
		(result_out.distance == '0) && !result_out.reachable)
		else $error("status result with pair fields set");

	// An unreachable pair reports distance zero.
	a_unreach_zero: assert property (@(posedge clk) disable iff (!arst_n)
		result_out.valid && !result_out.reachable |-> (result_out.distance == '0))
		else $error("unreachable pair with non-zero distance");

	// No datapath operation is issued while edges are being taken.
	a_idle_quiet: assert property (@(posedge clk) disable iff (!arst_n)
		edge_ready |-> (cmd.op == apsp_pkg::OP_NOP))
		else $error("operation issued while idle");

endmodule
